// ----- rtl/mab_pkg.sv -----
// ----------------------------------------------------------------------------
// mab_pkg: shared types and constants of the motion armed buzzer alarm
// Field widths, register codes, command codes, reset values and the
// structs that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package mab_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CMD_W       = 2;
    localparam int LIGHT_W     = 23;
    localparam int LUX_W       = 17;
    localparam int THR_W       = 15;
    localparam int THR_SQ_W    = 2 * THR_W;
    localparam int HALF_W      = 4;
    localparam int TONE_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;

    // one axis squared, and the sum of three of them
    localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W = 2 * SAMPLE_BITS;
    localparam int CMP_W = (SUM_W > THR_SQ_W) ? SUM_W : THR_SQ_W;

    // lux = light_raw / 100 by reciprocal, off by at most one low
    localparam int LUX_DIV    = 100;
    localparam int RECIP_SH   = 22;
    localparam int RECIP_W    = 16;
    localparam int RECIP      = (1 << RECIP_SH) / LUX_DIV;
    localparam int LUX_PROD_W = LIGHT_W + RECIP_W;

    localparam int ACCEL_THR_RST = 200;
    localparam int GYRO_THR_RST  = 18000;
    localparam logic [THR_SQ_W-1:0] ACCEL_SQ_RST =
        THR_SQ_W'(ACCEL_THR_RST * ACCEL_THR_RST);
    localparam logic [THR_SQ_W-1:0] GYRO_SQ_RST =
        THR_SQ_W'(GYRO_THR_RST * GYRO_THR_RST);
    localparam logic [LUX_W-1:0]  LIGHT_DELTA_RST = LUX_W'(300);
    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(12);
    localparam logic [TONE_W-1:0] TONE_HZ_RST     = TONE_W'(2000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_THR   = 3'd0,
        CFG_GYRO_THR    = 3'd1,
        CFG_LIGHT_DELTA = 3'd2,
        CFG_HALF_PERIOD = 3'd3,
        CFG_TONE_HZ     = 3'd4
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOTION = 2'd0,
        CMD_LIGHT  = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [THR_SQ_W-1:0] accel_sq;
        logic [THR_SQ_W-1:0] gyro_sq;
        logic [LUX_W-1:0]    light_delta;
        logic [HALF_W-1:0]   half_period;
        logic [TONE_W-1:0]   tone_hz;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic drain;
    } t_stage_ctl;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [SAMPLE_BITS-1:0] accel_x;
        logic [SAMPLE_BITS-1:0] accel_y;
        logic [SAMPLE_BITS-1:0] accel_z;
        logic [SAMPLE_BITS-1:0] rate_x;
        logic [SAMPLE_BITS-1:0] rate_y;
        logic [SAMPLE_BITS-1:0] rate_z;
        logic [LIGHT_W-1:0]     light_raw;
        logic                   light_bad;
    } t_sample;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SQ_W-1:0]    acc_sq_x;
        logic [SQ_W-1:0]    acc_sq_y;
        logic [SQ_W-1:0]    acc_sq_z;
        logic [SQ_W-1:0]    gyr_sq_x;
        logic [SQ_W-1:0]    gyr_sq_y;
        logic [SQ_W-1:0]    gyr_sq_z;
        logic [LIGHT_W-1:0] light_raw;
        logic [LUX_W-1:0]   lux_est;
        logic               light_bad;
    } t_front;

endpackage

// ----- rtl/motion_armed_buzzer_alarm.sv -----
// an accepted item passes the input, front and result registers in turn
// throughput: one item per cycle while i_ready does not stall the output; the alarm state
//   closes its loop in the decision stage, one update per item
// a stalled result holds in the result register while empty stages keep filling
// reset: pipeline emptied, alarm idle with baseline and phase cleared,
//   registers back to their defaults
// ----------------------------------------------------------------------------
// motion_armed_buzzer_alarm: motion armed alarm with buzzer timing
// Input register, squaring stage and decision stage with result register.
// ----------------------------------------------------------------------------
module motion_armed_buzzer_alarm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [mab_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_rate_x,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_rate_y,
    input  logic signed [mab_pkg::SAMPLE_BITS-1:0] i_rate_z,
    input  logic [mab_pkg::LIGHT_W-1:0]        i_light_raw,
    input  logic                               i_light_bad,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_buzzer_on,
    output logic [mab_pkg::TONE_W-1:0]         o_tone_out,
    output logic                               o_armed,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mab_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mab_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mab_pkg::*;

    t_cfg       cfg;
    logic       r_v1;
    t_sample    r_s1;
    logic       front_valid;
    t_front     front;
    t_stage_ctl front_ctl;
    t_stage_ctl ctrl_ctl;
    logic       s3_free;
    logic       s2_move;
    logic       s2_free;
    logic       s1_move;
    logic       accept;

    // bubbles collapse: a stage moves on when the one after it is free
    assign s3_free = !o_valid || i_ready;
    assign s2_move = front_valid && s3_free;
    assign s2_free = !front_valid || s2_move;
    assign s1_move = r_v1 && s2_free;
    assign o_ready = !r_v1 || s1_move;
    assign accept  = i_valid && o_ready;

    assign front_ctl.load  = s1_move;
    assign front_ctl.drain = s2_move;
    assign ctrl_ctl.load   = s2_move;
    assign ctrl_ctl.drain  = i_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (accept) begin
            r_v1 <= 1'b1;
        end else if (s1_move) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.cmd       <= i_cmd;
            r_s1.accel_x   <= i_accel_x;
            r_s1.accel_y   <= i_accel_y;
            r_s1.accel_z   <= i_accel_z;
            r_s1.rate_x    <= i_rate_x;
            r_s1.rate_y    <= i_rate_y;
            r_s1.rate_z    <= i_rate_z;
            r_s1.light_raw <= i_light_raw;
            r_s1.light_bad <= i_light_bad;
        end
    end

    mab_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mab_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (front_ctl),
        .i_sample (r_s1),
        .o_valid  (front_valid),
        .o_front  (front)
    );

    mab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctrl_ctl),
        .i_front     (front),
        .i_cfg       (cfg),
        .o_valid     (o_valid),
        .o_buzzer_on (o_buzzer_on),
        .o_tone_out  (o_tone_out),
        .o_armed     (o_armed)
    );

    // the buzzer only sounds while armed
    a_buzz_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_armed |-> !o_buzzer_on)
        else $error("buzzer on while disarmed");

    a_tone_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_buzzer_on |-> o_tone_out == '0)
        else $error("tone reported while silent");

    // an accepted item always lands in the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted item lost at input stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !front_valid && !r_v1)
        else $error("pipeline not empty after reset");

endmodule

// ----- rtl/mab_cfg.sv -----
// ----------------------------------------------------------------------------
// mab_cfg: configuration registers
// Holds the alarm settings; thresholds are kept squared, formed on write.
// ----------------------------------------------------------------------------
module mab_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mab_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output mab_pkg::t_cfg                  o_cfg
);
    import mab_pkg::*;

    t_cfg                r_cfg;
    logic [THR_W-1:0]    thr;
    logic [THR_SQ_W-1:0] thr_sq;

    assign thr    = i_cfg_data[THR_W-1:0];
    assign thr_sq = THR_SQ_W'(thr) * THR_SQ_W'(thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_sq    <= ACCEL_SQ_RST;
            r_cfg.gyro_sq     <= GYRO_SQ_RST;
            r_cfg.light_delta <= LIGHT_DELTA_RST;
            r_cfg.half_period <= HALF_PERIOD_RST;
            r_cfg.tone_hz     <= TONE_HZ_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ACCEL_THR:   r_cfg.accel_sq    <= thr_sq;
                CFG_GYRO_THR:    r_cfg.gyro_sq     <= thr_sq;
                CFG_LIGHT_DELTA: r_cfg.light_delta <= i_cfg_data[LUX_W-1:0];
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data[HALF_W-1:0];
                CFG_TONE_HZ:     r_cfg.tone_hz     <= i_cfg_data[TONE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/mab_front.sv -----
// ----------------------------------------------------------------------------
// mab_front: arithmetic stage
// Squares every motion axis and estimates the lux value, all registered.
// ----------------------------------------------------------------------------
module mab_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mab_pkg::t_stage_ctl i_ctl,
    input  mab_pkg::t_sample    i_sample,
    output logic                o_valid,
    output mab_pkg::t_front     o_front
);
    import mab_pkg::*;

    function automatic logic [SQ_W-1:0] square(input logic [SAMPLE_BITS-1:0] v);
        logic signed [SAMPLE_BITS-1:0] s;
        logic signed [SUM_W-1:0]       p;
        s = $signed(v);
        p = s * s;
        return p[SQ_W-1:0];
    endfunction

    logic                  r_valid;
    t_front                r_front;
    t_front                n_front;
    logic [LUX_PROD_W-1:0] lux_prod;

    assign lux_prod = LUX_PROD_W'(i_sample.light_raw) * LUX_PROD_W'(RECIP);

    always_comb begin
        n_front.cmd       = i_sample.cmd;
        n_front.acc_sq_x  = square(i_sample.accel_x);
        n_front.acc_sq_y  = square(i_sample.accel_y);
        n_front.acc_sq_z  = square(i_sample.accel_z);
        n_front.gyr_sq_x  = square(i_sample.rate_x);
        n_front.gyr_sq_y  = square(i_sample.rate_y);
        n_front.gyr_sq_z  = square(i_sample.rate_z);
        n_front.light_raw = i_sample.light_raw;
        n_front.lux_est   = lux_prod[RECIP_SH +: LUX_W];
        n_front.light_bad = i_sample.light_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_front <= n_front;
        end
    end

    assign o_valid = r_valid;
    assign o_front = r_front;

endmodule

// ----- rtl/mab_ctrl.sv -----
// ----------------------------------------------------------------------------
// mab_ctrl: decision stage and result register
// Compares magnitudes, tracks the light baseline, steps the buzz phase
// and registers the outputs of each item.
// ----------------------------------------------------------------------------
module mab_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mab_pkg::t_stage_ctl        i_ctl,
    input  mab_pkg::t_front            i_front,
    input  mab_pkg::t_cfg              i_cfg,
    output logic                       o_valid,
    output logic                       o_buzzer_on,
    output logic [mab_pkg::TONE_W-1:0] o_tone_out,
    output logic                       o_armed
);
    import mab_pkg::*;

    logic               r_valid;
    logic               r_active,    n_active;
    logic [HALF_W-1:0]  r_phase_cnt, n_phase_cnt;
    logic               r_sound_ph,  n_sound_ph;
    logic [LUX_W-1:0]   r_prev_lux,  n_prev_lux;
    logic               r_prev_ok,   n_prev_ok;
    logic               r_sounding,  n_sounding;
    logic               r_buzz;
    logic [TONE_W-1:0]  r_tone;
    logic               r_armed;

    logic [SUM_W-1:0]   acc_sum;
    logic [SUM_W-1:0]   gyr_sum;
    logic               over;
    logic [LIGHT_W:0]   lux_back;
    logic [LIGHT_W:0]   lux_rem;
    logic [LUX_W-1:0]   lux;
    logic [LUX_W-1:0]   lux_diff;
    logic [HALF_W-1:0]  cnt_next;

    assign acc_sum = SUM_W'(i_front.acc_sq_x) + SUM_W'(i_front.acc_sq_y)
                   + SUM_W'(i_front.acc_sq_z);
    assign gyr_sum = SUM_W'(i_front.gyr_sq_x) + SUM_W'(i_front.gyr_sq_y)
                   + SUM_W'(i_front.gyr_sq_z);
    assign over = (CMP_W'(acc_sum) > CMP_W'(i_cfg.accel_sq))
               || (CMP_W'(gyr_sum) > CMP_W'(i_cfg.gyro_sq));

    // fix up the reciprocal estimate with one compare
    assign lux_back = (LIGHT_W + 1)'(i_front.lux_est) * (LIGHT_W + 1)'(LUX_DIV);
    assign lux_rem  = (LIGHT_W + 1)'(i_front.light_raw) - lux_back;
    assign lux      = i_front.lux_est
                    + LUX_W'(lux_rem >= (LIGHT_W + 1)'(LUX_DIV));
    assign lux_diff = (lux >= r_prev_lux) ? (lux - r_prev_lux) : (r_prev_lux - lux);

    assign cnt_next = (r_phase_cnt < i_cfg.half_period) ? (r_phase_cnt + 1'b1)
                                                        : '0;

    always_comb begin
        n_active    = r_active;
        n_phase_cnt = r_phase_cnt;
        n_sound_ph  = r_sound_ph;
        n_prev_lux  = r_prev_lux;
        n_prev_ok   = r_prev_ok;
        n_sounding  = r_sounding;
        case (t_cmd'(i_front.cmd))
            CMD_MOTION: begin
                if (!r_active && over) begin
                    n_active    = 1'b1;
                    n_sound_ph  = 1'b1;
                    n_phase_cnt = '0;
                end
            end
            CMD_LIGHT: begin
                if (r_active && !i_front.light_bad) begin
                    if (!r_prev_ok) begin
                        n_prev_lux = lux;
                        n_prev_ok  = 1'b1;
                    end else if (lux_diff >= i_cfg.light_delta) begin
                        // disarm, everything back to reset
                        n_active    = 1'b0;
                        n_phase_cnt = '0;
                        n_sound_ph  = 1'b0;
                        n_prev_lux  = '0;
                        n_prev_ok   = 1'b0;
                        n_sounding  = 1'b0;
                    end else begin
                        n_prev_lux = lux;
                    end
                end
            end
            CMD_TICK: begin
                if (r_active) begin
                    if (r_sound_ph && r_phase_cnt == '0) begin
                        n_sounding = 1'b1;
                    end else if (r_sound_ph && r_phase_cnt == i_cfg.half_period) begin
                        n_sounding = 1'b0;
                    end
                    n_phase_cnt = cnt_next;
                    if (cnt_next == '0) begin
                        n_sound_ph = !r_sound_ph;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_active    <= 1'b0;
            r_phase_cnt <= '0;
            r_sound_ph  <= 1'b0;
            r_prev_lux  <= '0;
            r_prev_ok   <= 1'b0;
            r_sounding  <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid     <= 1'b1;
            r_active    <= n_active;
            r_phase_cnt <= n_phase_cnt;
            r_sound_ph  <= n_sound_ph;
            r_prev_lux  <= n_prev_lux;
            r_prev_ok   <= n_prev_ok;
            r_sounding  <= n_sounding;
        end else if (i_ctl.drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_buzz  <= n_sounding;
            r_tone  <= n_sounding ? i_cfg.tone_hz : '0;
            r_armed <= n_active;
        end
    end

    assign o_valid     = r_valid;
    assign o_buzzer_on = r_buzz;
    assign o_tone_out  = r_tone;
    assign o_armed     = r_armed;

endmodule
